>>> hdl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies; every other file in hdl/ imports this package.
package i2cm_pkg;

    localparam int HALF_W         = 8;
    localparam int LIMIT_W        = 20;
    localparam int BYTE_BITS      = 8;
    localparam int RECOVER_PULSES = 9;
    localparam int BC_W           = 4;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 20;
    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [HALF_W-1:0]  HALF_RESET  = HALF_W'(5);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_STOP    = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_READ    = 3'd3,
        CMD_RECOVER = 3'd4
    } cmd_t;

    // classified tick, as passed from the front end to the engine
    typedef struct packed {
        logic       cmd_ok;
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       rd_ack;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack;
        logic       stretch_timeout;
    } result_t;

endpackage

>>> hdl/i2cm_ifs.sv
// Handshake channel interfaces: tick input, result output, register write.
// Depends on i2cm_pkg.
interface i2cm_cmd_if;
    import i2cm_pkg::*;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       rd_ack;
    logic       scl_in;
    logic       sda_in;
    modport source (output valid, cmd_valid, mode, tx_byte, rd_ack, scl_in, sda_in,
                    input ready);
    modport sink (input valid, cmd_valid, mode, tx_byte, rd_ack, scl_in, sda_in,
                  output ready);
endinterface

interface i2cm_res_if;
    import i2cm_pkg::*;
    logic       valid;
    logic       ready;
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
    logic       stretch_timeout;
    modport source (output valid, scl_low, sda_low, busy_res, done_res, rx_byte, nack,
                    stretch_timeout, input ready);
    modport sink (input valid, scl_low, sda_low, busy_res, done_res, rx_byte, nack,
                  stretch_timeout, output ready);
endinterface

interface i2cm_cfg_if;
    import i2cm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/i2cm_front.sv
// Front end: takes tick transactions, classifies the command field, registers them.
// Depends on i2cm_pkg and i2cm_ifs.
module i2cm_front (
    input  logic               clk,
    input  logic               rst_n,
    i2cm_cmd_if.sink           cmd,
    output i2cm_pkg::item_t    item,
    output logic               item_valid,
    input  logic               item_ready
);
    import i2cm_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign cmd.ready  = !valid_reg || item_ready;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_comb
    begin
        item_next.cmd_ok   = cmd.cmd_valid && (cmd.mode <= CMD_RECOVER);
        item_next.cmd      = cmd_t'(cmd.mode);
        item_next.tx_byte  = cmd.tx_byte;
        item_next.rd_ack   = cmd.rd_ack;
        item_next.scl_in   = cmd.scl_in;
        item_next.sda_in   = cmd.sda_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> hdl/i2cm_fifo.sv
// Short queue of classified ticks between front end and engine.
// Depends on i2cm_pkg.
module i2cm_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  i2cm_pkg::item_t    push_item,
    input  logic               push_valid,
    output logic               push_ready,
    output i2cm_pkg::item_t    pop_item,
    output logic               pop_valid,
    input  logic               pop
);
    import i2cm_pkg::*;

    item_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/i2cm_back.sv
// Bus sequencer: walks the step sequence of each command, one tick per pop,
// holds the timing registers and the result register. Depends on i2cm_pkg, i2cm_ifs.
module i2cm_back (
    input  logic               clk,
    input  logic               rst_n,
    i2cm_cfg_if.sink           cfg,
    input  i2cm_pkg::item_t    item,
    input  logic               item_valid,
    output logic               item_pop,
    i2cm_res_if.source         res
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE,
        ST_A, ST_B, ST_C, ST_D, ST_E,
        SP_A, SP_B, SP_C, SP_D,
        WB_A, WB_B, WB_C, WA_A, WA_B, WA_C, WA_D,
        RB_A, RB_B, RB_C, RK_A, RK_B, RK_C, RK_D,
        RC_A, RC_B, RC_C
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [BC_W-1:0]    bc_reg, bc_next;
    logic [7:0]         shift_reg, shift_next;
    logic               ack_reg, ack_next;
    logic [HALF_W-1:0]  half_timer_reg, half_timer_next;
    logic [LIMIT_W-1:0] stretch_timer_reg, stretch_timer_next;
    logic               scl_low_reg, scl_low_next;
    logic               sda_low_reg, sda_low_next;
    logic [7:0]         rx_reg, rx_next;
    logic               nack_reg, nack_next;
    logic               timeout_reg, timeout_next;
    logic [HALF_W-1:0]  half_period_reg;
    logic [LIMIT_W-1:0] stretch_limit_reg;
    logic               out_valid_reg;
    result_t            result_reg, result_next;
    logic               advance;
    logic               enter;
    logic               done;
    logic [HALF_W-1:0]  half_inc;

    function automatic logic is_release(phase_t p);
        return (p == ST_B) || (p == SP_B) || (p == WB_B) || (p == WA_B) ||
               (p == RB_B) || (p == RK_B) || (p == RC_B);
    endfunction

    function automatic phase_t first_phase(cmd_t c);
        phase_t p;
        case (c)
            CMD_START:   p = ST_A;
            CMD_STOP:    p = SP_A;
            CMD_WRITE:   p = WB_A;
            CMD_READ:    p = RB_A;
            CMD_RECOVER: p = RC_A;
            default:     p = PH_IDLE;
        endcase
        return p;
    endfunction

    assign item_pop  = item_valid && (!out_valid_reg || res.ready);
    assign cfg.ready = 1'b1;
    assign half_inc  = (half_timer_reg != '1) ? half_timer_reg + 1'b1 : half_timer_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        bc_next            = bc_reg;
        shift_next         = shift_reg;
        ack_next           = ack_reg;
        half_timer_next    = half_timer_reg;
        stretch_timer_next = stretch_timer_reg;
        scl_low_next       = scl_low_reg;
        sda_low_next       = sda_low_reg;
        rx_next            = rx_reg;
        nack_next          = nack_reg;
        timeout_next       = timeout_reg;
        advance            = 1'b0;
        enter              = 1'b0;
        done               = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd_ok)
            begin
                bc_next            = '0;
                half_timer_next    = '0;
                stretch_timer_next = '0;
                timeout_next       = 1'b0;
                ack_next           = item.rd_ack;
                if (item.cmd == CMD_WRITE)
                begin
                    shift_next = item.tx_byte;
                    nack_next  = 1'b0;
                end
                else if (item.cmd == CMD_READ)
                begin
                    shift_next = '0;
                end
                phase_next = first_phase(item.cmd);
                enter      = 1'b1;
            end
        end
        else if (is_release(phase_reg))
        begin
            if (item.scl_in)
            begin
                advance = 1'b1;
            end
            else if (stretch_timer_reg >= stretch_limit_reg)
            begin
                timeout_next = 1'b1;
                advance      = 1'b1;
            end
            else
            begin
                stretch_timer_next = stretch_timer_reg + 1'b1;
            end
        end
        else
        begin
            half_timer_next = half_inc;
            advance         = (half_inc >= half_period_reg);
        end

        if (advance)
        begin
            half_timer_next    = '0;
            stretch_timer_next = '0;
            case (phase_reg)
                ST_A: phase_next = ST_B;
                ST_B: phase_next = ST_C;
                ST_C: phase_next = ST_D;
                ST_D: phase_next = ST_E;
                SP_A: phase_next = SP_B;
                SP_B: phase_next = SP_C;
                SP_C: phase_next = SP_D;
                WB_A: phase_next = WB_B;
                WB_B: phase_next = WB_C;
                WB_C:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bc_next    = bc_reg + 1'b1;
                    phase_next = (bc_next < BC_W'(BYTE_BITS)) ? WB_A : WA_A;
                end
                WA_A: phase_next = WA_B;
                WA_B: phase_next = WA_C;
                WA_C:
                begin
                    nack_next  = item.sda_in;
                    phase_next = WA_D;
                end
                RB_A: phase_next = RB_B;
                RB_B:
                begin
                    shift_next = {shift_reg[6:0], item.sda_in};
                    phase_next = RB_C;
                end
                RB_C:
                begin
                    bc_next    = bc_reg + 1'b1;
                    phase_next = (bc_next < BC_W'(BYTE_BITS)) ? RB_A : RK_A;
                end
                RK_A: phase_next = RK_B;
                RK_B: phase_next = RK_C;
                RK_C: phase_next = RK_D;
                RK_D:
                begin
                    rx_next    = shift_reg;
                    phase_next = PH_IDLE;
                end
                RC_A: phase_next = RC_B;
                RC_B: phase_next = RC_C;
                RC_C:
                begin
                    if ((BC_W + 1)'(bc_reg) + 1'b1 < (BC_W + 1)'(RECOVER_PULSES))
                    begin
                        bc_next    = bc_reg + 1'b1;
                        phase_next = RC_A;
                    end
                    else
                    begin
                        phase_next = SP_A;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
            if (phase_next == PH_IDLE)
            begin
                done = 1'b1;
            end
            else
            begin
                enter = 1'b1;
            end
        end

        // line drive set on entry to a step
        if (enter)
        begin
            case (phase_next)
                ST_A: sda_low_next = 1'b0;
                ST_D: sda_low_next = 1'b1;
                ST_E: scl_low_next = 1'b1;
                SP_A: sda_low_next = 1'b1;
                SP_D: sda_low_next = 1'b0;
                WB_A:
                begin
                    if (bc_next != '0)
                    begin
                        scl_low_next = 1'b1;
                    end
                    sda_low_next = !shift_next[7];
                end
                WA_A:
                begin
                    scl_low_next = 1'b1;
                    sda_low_next = 1'b0;
                end
                WA_D: scl_low_next = 1'b1;
                RB_A:
                begin
                    sda_low_next = 1'b0;
                    if (bc_next != '0)
                    begin
                        scl_low_next = 1'b1;
                    end
                end
                RK_A:
                begin
                    scl_low_next = 1'b1;
                    sda_low_next = ack_next;
                end
                RK_D, RC_A:
                begin
                    scl_low_next = 1'b1;
                    sda_low_next = 1'b0;
                end
                default:
                begin
                    if (is_release(phase_next))
                    begin
                        scl_low_next = 1'b0;
                    end
                end
            endcase
        end

        result_next.scl_low         = scl_low_next;
        result_next.sda_low         = sda_low_next;
        result_next.busy_res        = (phase_next != PH_IDLE);
        result_next.done_res        = done;
        result_next.rx_byte         = rx_next;
        result_next.nack            = nack_next;
        result_next.stretch_timeout = timeout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bc_reg            <= '0;
            shift_reg         <= '0;
            ack_reg           <= 1'b0;
            half_timer_reg    <= '0;
            stretch_timer_reg <= '0;
            scl_low_reg       <= 1'b0;
            sda_low_reg       <= 1'b0;
            rx_reg            <= '0;
            nack_reg          <= 1'b0;
            timeout_reg       <= 1'b0;
            half_period_reg   <= HALF_RESET;
            stretch_limit_reg <= LIMIT_RESET;
            out_valid_reg     <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == CFG_HALF_PERIOD)
                begin
                    half_period_reg <= cfg.data[HALF_W-1:0];
                end
                else if (cfg.index == CFG_STRETCH_LIMIT)
                begin
                    stretch_limit_reg <= cfg.data[LIMIT_W-1:0];
                end
            end
            if (item_pop)
            begin
                phase_reg         <= phase_next;
                bc_reg            <= bc_next;
                shift_reg         <= shift_next;
                ack_reg           <= ack_next;
                half_timer_reg    <= half_timer_next;
                stretch_timer_reg <= stretch_timer_next;
                scl_low_reg       <= scl_low_next;
                sda_low_reg       <= sda_low_next;
                rx_reg            <= rx_next;
                nack_reg          <= nack_next;
                timeout_reg       <= timeout_next;
                out_valid_reg     <= 1'b1;
                result_reg        <= result_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.scl_low         = result_reg.scl_low;
    assign res.sda_low         = result_reg.sda_low;
    assign res.busy_res        = result_reg.busy_res;
    assign res.done_res        = result_reg.done_res;
    assign res.rx_byte         = result_reg.rx_byte;
    assign res.nack            = result_reg.nack;
    assign res.stretch_timeout = result_reg.stretch_timeout;

endmodule

>>> hdl/i2c_master_bit_engine.sv
// I2C master bit engine top level: front end, tick queue, bus sequencer.
// Path: a tick passes the front-end register, the tick queue, then the result register.
// Throughput: one tick per clock unless res.ready stalls it, set by the step update.
// Reset (rst_n low, asynchronous): idle, both lines released, queue empty,
// half_period 5, stretch_limit 10000. Depends on i2cm_pkg, i2cm_ifs and submodules.
module i2c_master_bit_engine (
    input  logic       clk,
    input  logic       rst_n,
    i2cm_cmd_if.sink   cmd,
    i2cm_cfg_if.sink   cfg,
    i2cm_res_if.source res
);
    import i2cm_pkg::*;

    item_t front_item;
    logic  front_valid;
    logic  fifo_ready;
    item_t queue_item;
    logic  queue_valid;
    logic  queue_pop;

    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (fifo_ready)
    );

    i2cm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (fifo_ready),
        .pop_item   (queue_item),
        .pop_valid  (queue_valid),
        .pop        (queue_pop)
    );

    i2cm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (queue_item),
        .item_valid (queue_valid),
        .item_pop   (queue_pop),
        .res        (res)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for i2c_master_bit_engine: drives timing ticks with bus line samples
// and checks every per-tick output against a cycle-true predictor of the engine.
// Depends on i2cm_pkg, the channel interfaces in i2cm_ifs and the engine RTL.
module testbench;
    import i2cm_pkg::*;

    localparam int RES_LATENCY = 2;
    localparam int QUIET_LIMIT = 2000;
    localparam int TOTAL_TICKS = 950;
    localparam int PHASE_TICKS = 130;
    // no register behind this index
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(15);

    typedef enum logic [4:0] {
        BUS_IDLE,
        ST_SETUP, ST_RISE, ST_HIGH, ST_FALL_SDA, ST_FALL_SCL,
        SP_PREP, SP_RISE, SP_HIGH, SP_FREE,
        WR_DATA, WR_RISE, WR_HIGH, WA_PREP, WA_RISE, WA_READ, WA_END,
        RD_PREP, RD_RISE, RD_HIGH, RA_DRIVE, RA_RISE, RA_HIGH, RA_END,
        RC_LOW, RC_RISE, RC_HIGH
    } bus_step_e;

    typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_style_e;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       rd_ack;
        logic       scl_in;
        logic       sda_in;
    } tick_t;

    class bus_tick_scoreboard;
        logic [HALF_W-1:0]  half_period;
        logic [LIMIT_W-1:0] stretch_limit;
        bus_step_e          cur_step;
        logic [BC_W-1:0]    bit_cnt;
        logic [7:0]         shifter;
        logic               ack_sel;
        logic [HALF_W-1:0]  half_cnt;
        logic [LIMIT_W-1:0] stretch_cnt;
        logic               drv_scl;
        logic               drv_sda;
        logic [7:0]         rx_last;
        logic               nack_last;
        logic               timeout_last;
        result_t            expected_outputs[$];
        int                 errors;
        int                 seen;

        function new();
            half_period = HALF_RESET;
            stretch_limit = LIMIT_RESET;
            cur_step = BUS_IDLE;
            bit_cnt = '0;
            shifter = '0;
            ack_sel = 1'b0;
            half_cnt = '0;
            stretch_cnt = '0;
            drv_scl = 1'b0;
            drv_sda = 1'b0;
            rx_last = '0;
            nack_last = 1'b0;
            timeout_last = 1'b0;
            errors = 0;
            seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_HALF_PERIOD)
                half_period = data[HALF_W-1:0];
            else if (idx == CFG_STRETCH_LIMIT)
                stretch_limit = data[LIMIT_W-1:0];
        endfunction

        function bit is_rise(bus_step_e s);
            return s inside {ST_RISE, SP_RISE, WR_RISE, WA_RISE, RD_RISE, RA_RISE, RC_RISE};
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void enter_step(bus_step_e s);
            case (s)
                ST_SETUP:    drv_sda = 1'b0;
                ST_FALL_SDA: drv_sda = 1'b1;
                ST_FALL_SCL: drv_scl = 1'b1;
                SP_PREP:     drv_sda = 1'b1;
                SP_FREE:     drv_sda = 1'b0;
                WR_DATA:
                begin
                    if (bit_cnt != 0)
                        drv_scl = 1'b1;
                    drv_sda = ~shifter[7];
                end
                WA_PREP:
                begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b0;
                end
                WA_END:      drv_scl = 1'b1;
                RD_PREP:
                begin
                    drv_sda = 1'b0;
                    if (bit_cnt != 0)
                        drv_scl = 1'b1;
                end
                RA_DRIVE:
                begin
                    drv_scl = 1'b1;
                    drv_sda = ack_sel;
                end
                RA_END, RC_LOW:
                begin
                    drv_scl = 1'b1;
                    drv_sda = 1'b0;
                end
                default:
                begin
                    if (is_rise(s))
                        drv_scl = 1'b0;
                end
            endcase
        endfunction

        function bus_step_e leave_step(bus_step_e s, logic sda);
            case (s)
                ST_SETUP:    return ST_RISE;
                ST_RISE:     return ST_HIGH;
                ST_HIGH:     return ST_FALL_SDA;
                ST_FALL_SDA: return ST_FALL_SCL;
                SP_PREP:     return SP_RISE;
                SP_RISE:     return SP_HIGH;
                SP_HIGH:     return SP_FREE;
                WR_DATA:     return WR_RISE;
                WR_RISE:     return WR_HIGH;
                WR_HIGH:
                begin
                    shifter = {shifter[6:0], 1'b0};
                    bit_cnt++;
                    return (bit_cnt < BYTE_BITS) ? WR_DATA : WA_PREP;
                end
                WA_PREP:     return WA_RISE;
                WA_RISE:     return WA_READ;
                WA_READ:
                begin
                    nack_last = sda;
                    return WA_END;
                end
                RD_PREP:     return RD_RISE;
                RD_RISE:
                begin
                    shifter = {shifter[6:0], sda};
                    return RD_HIGH;
                end
                RD_HIGH:
                begin
                    bit_cnt++;
                    return (bit_cnt < BYTE_BITS) ? RD_PREP : RA_DRIVE;
                end
                RA_DRIVE:    return RA_RISE;
                RA_RISE:     return RA_HIGH;
                RA_HIGH:     return RA_END;
                RA_END:
                begin
                    rx_last = shifter;
                    return BUS_IDLE;
                end
                RC_LOW:      return RC_RISE;
                RC_RISE:     return RC_HIGH;
                RC_HIGH:
                begin
                    if (int'(bit_cnt) + 1 < RECOVER_PULSES)
                    begin
                        bit_cnt++;
                        return RC_LOW;
                    end
                    return SP_PREP;
                end
                default:     return BUS_IDLE;
            endcase
        endfunction

        // one accepted tick: advance the engine and queue the outputs it shows
        function void apply_tick(tick_t t);
            logic      adv;
            logic      done_now;
            bus_step_e nxt;
            result_t   r;
            adv = 1'b0;
            done_now = 1'b0;
            if (cur_step == BUS_IDLE)
            begin
                if (t.cmd_valid && t.mode <= CMD_RECOVER)
                begin
                    bit_cnt = '0;
                    half_cnt = '0;
                    stretch_cnt = '0;
                    timeout_last = 1'b0;
                    ack_sel = t.rd_ack;
                    case (t.mode)
                        CMD_START: cur_step = ST_SETUP;
                        CMD_STOP:  cur_step = SP_PREP;
                        CMD_WRITE:
                        begin
                            shifter = t.tx_byte;
                            nack_last = 1'b0;
                            cur_step = WR_DATA;
                        end
                        CMD_READ:
                        begin
                            shifter = '0;
                            cur_step = RD_PREP;
                        end
                        default:   cur_step = RC_LOW;
                    endcase
                    enter_step(cur_step);
                end
            end
            else if (is_rise(cur_step))
            begin
                if (t.scl_in)
                    adv = 1'b1;
                else if (stretch_cnt >= stretch_limit)
                begin
                    timeout_last = 1'b1;
                    adv = 1'b1;
                end
                else
                    stretch_cnt++;
            end
            else
            begin
                if (half_cnt != '1)
                    half_cnt++;
                if (half_cnt >= half_period)
                    adv = 1'b1;
            end
            if (adv)
            begin
                nxt = leave_step(cur_step, t.sda_in);
                half_cnt = '0;
                stretch_cnt = '0;
                cur_step = nxt;
                if (nxt == BUS_IDLE)
                    done_now = 1'b1;
                else
                    enter_step(nxt);
            end
            r.scl_low = drv_scl;
            r.sda_low = drv_sda;
            r.busy_res = (cur_step != BUS_IDLE);
            r.done_res = done_now;
            r.rx_byte = rx_last;
            r.nack = nack_last;
            r.stretch_timeout = timeout_last;
            expected_outputs.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task compare(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("output %0d %s: got %h, want %h", seen, name, got, want));
        endtask

        task check_output(result_t got);
            result_t want;
            if (expected_outputs.size() == 0)
            begin
                report($sformatf("output %0d arrived with nothing expected", seen));
                seen++;
                return;
            end
            want = expected_outputs.pop_front();
            compare("scl_low", 8'(got.scl_low), 8'(want.scl_low));
            compare("sda_low", 8'(got.sda_low), 8'(want.sda_low));
            compare("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            compare("done_res", 8'(got.done_res), 8'(want.done_res));
            compare("rx_byte", got.rx_byte, want.rx_byte);
            compare("nack", 8'(got.nack), 8'(want.nack));
            compare("stretch_timeout", 8'(got.stretch_timeout), 8'(want.stretch_timeout));
            seen++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    i2cm_cmd_if cmd_ch ();
    i2cm_res_if res_ch ();
    i2cm_cfg_if cfg_ch ();

    i2c_master_bit_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .cfg   (cfg_ch),
        .res   (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    bus_tick_scoreboard sb;
    bit         calm[2];
    int         accepted_ticks;
    int         stretch_left;
    bus_step_e  last_step;
    sda_style_e sda_style;
    bit         noise_on;
    int         quiet_cycles;

    // wait cycles before the next transaction on one side, with runs of no waiting
    function automatic int draw_wait(int side);
        if ($urandom_range(0, 39) == 0)
            calm[side] = !calm[side];
        return calm[side] ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic int draw_stretch();
        int lim;
        int r;
        lim = int'(sb.stretch_limit);
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 8)
            return $urandom_range(1, 4);
        if (lim <= 40)
        begin
            // right at the limit, one past it, or well past it
            case ($urandom_range(0, 2))
                0:       return lim;
                1:       return lim + 1;
                default: return lim + $urandom_range(2, 4);
            endcase
        end
        return $urandom_range(5, 12);
    endfunction

    task automatic send_tick(tick_t t);
        int gap;
        gap = draw_wait(0);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.cmd_valid = t.cmd_valid;
        cmd_ch.mode = t.mode;
        cmd_ch.tx_byte = t.tx_byte;
        cmd_ch.rd_ack = t.rd_ack;
        cmd_ch.scl_in = t.scl_in;
        cmd_ch.sda_in = t.sda_in;
        cmd_ch.valid = 1'b1;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        sb.apply_tick(t);
        accepted_ticks++;
    endtask

    task automatic busy_tick();
        tick_t t;
        t.cmd_valid = noise_on && ($urandom_range(0, 3) == 0);
        t.mode = 3'($urandom_range(0, 7));
        t.tx_byte = 8'($urandom);
        t.rd_ack = 1'($urandom);
        if (sb.is_rise(sb.cur_step))
        begin
            if (sb.cur_step != last_step)
                stretch_left = draw_stretch();
            t.scl_in = (stretch_left == 0);
            if (stretch_left > 0)
                stretch_left--;
        end
        else
            t.scl_in = ($urandom_range(0, 9) == 0) ? sb.drv_scl : !sb.drv_scl;
        case (sda_style)
            SDA_HIGH: t.sda_in = 1'b1;
            SDA_LOW:  t.sda_in = 1'b0;
            default:  t.sda_in = 1'($urandom);
        endcase
        last_step = sb.cur_step;
        send_tick(t);
    endtask

    task automatic idle_tick();
        tick_t t;
        t.cmd_valid = 1'b0;
        t.mode = 3'($urandom_range(0, 7));
        t.tx_byte = 8'($urandom);
        t.rd_ack = 1'($urandom);
        t.scl_in = !sb.drv_scl;
        t.sda_in = 1'($urandom);
        send_tick(t);
    endtask

    // issue one command and run ticks until the engine is idle again
    task automatic issue(logic [2:0] mode, logic [7:0] data_byte, logic ack);
        tick_t t;
        t.cmd_valid = 1'b1;
        t.mode = mode;
        t.tx_byte = data_byte;
        t.rd_ack = ack;
        t.scl_in = !sb.drv_scl;
        t.sda_in = 1'($urandom);
        last_step = BUS_IDLE;
        send_tick(t);
        while (sb.cur_step != BUS_IDLE)
            busy_tick();
    endtask

    // stop sending ticks and let every expected output come back
    task automatic settle();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (RES_LATENCY + 4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data = data;
        cfg_ch.valid = 1'b1;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_timing(logic [HALF_W-1:0] half, logic [LIMIT_W-1:0] lim);
        settle();
        // upper data bits are don't-care for the half period register
        cfg_write(CFG_HALF_PERIOD, {12'($urandom), half});
        cfg_write(CFG_STRETCH_LIMIT, lim);
    endtask

    task automatic random_setting();
        logic [HALF_W-1:0]  half;
        logic [LIMIT_W-1:0] lim;
        half = ($urandom_range(0, 9) == 0) ? HALF_W'($urandom_range(7, 12))
                                           : HALF_W'($urandom_range(0, 4));
        case ($urandom_range(0, 5))
            0:       lim = '0;
            1:       lim = LIMIT_W'(1);
            2:       lim = LIMIT_W'($urandom_range(2, 16));
            3:       lim = LIMIT_W'($urandom_range(17, 40));
            4:       lim = LIMIT_RESET;
            default: lim = '1;
        endcase
        set_timing(half, lim);
    endtask

    task automatic random_transaction();
        int r;
        int n;
        r = $urandom_range(0, 19);
        case ($urandom_range(0, 7))
            0:       sda_style = SDA_HIGH;
            1:       sda_style = SDA_LOW;
            default: sda_style = SDA_RANDOM;
        endcase
        repeat ($urandom_range(0, 2)) idle_tick();
        if (r == 0)
            issue(CMD_RECOVER, 8'($urandom), 1'($urandom));
        else if (r == 1)
            issue(3'($urandom_range(int'(CMD_RECOVER) + 1, 7)), 8'($urandom), 1'($urandom));
        else if (r == 2)
            issue(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
        else
        begin
            // well-formed bus transaction: start, address, data bytes, maybe a repeated start, stop
            issue(CMD_START, 8'($urandom), 1'($urandom));
            issue(CMD_WRITE, 8'($urandom), 1'($urandom));
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                if ($urandom_range(0, 1) == 0)
                    issue(CMD_WRITE, 8'($urandom), 1'($urandom));
                else
                    issue(CMD_READ, 8'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 5) == 0)
                issue(CMD_START, 8'($urandom), 1'($urandom));
            issue(CMD_STOP, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic collect_outputs();
        result_t got;
        int      n;
        forever
        begin
            n = draw_wait(1);
            @(negedge clk);
            if (n > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            got = {res_ch.scl_low, res_ch.sda_low, res_ch.busy_res, res_ch.done_res,
                   res_ch.rx_byte, res_ch.nack, res_ch.stretch_timeout};
            sb.check_output(got);
        end
    endtask

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int phase_start;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd_valid = 1'b0;
        cmd_ch.mode = '0;
        cmd_ch.tx_byte = '0;
        cmd_ch.rd_ack = 1'b0;
        cmd_ch.scl_in = 1'b1;
        cmd_ch.sda_in = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        quiet_cycles = 0;
        accepted_ticks = 0;
        stretch_left = 0;
        last_step = BUS_IDLE;
        sda_style = SDA_RANDOM;
        noise_on = 1'b1;
        sb = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        fork
            collect_outputs();
        join_none

        // reset timing values
        sda_style = SDA_HIGH;
        issue(CMD_START, 8'h00, 1'b0);
        issue(CMD_WRITE, 8'hFF, 1'b0);
        issue(CMD_READ, 8'h00, 1'b1);
        sda_style = SDA_RANDOM;
        issue(CMD_STOP, 8'h00, 1'b0);

        // zero stretch limit: any held-low SCL times out
        set_timing(HALF_W'(2), '0);
        issue(CMD_WRITE, 8'h00, 1'b1);
        sda_style = SDA_LOW;
        issue(CMD_READ, 8'hFF, 1'b0);
        sda_style = SDA_RANDOM;
        issue(CMD_RECOVER, 8'h00, 1'b0);
        for (int m = int'(CMD_RECOVER) + 1; m < 8; m++)
            issue(3'(m), 8'($urandom), 1'($urandom));
        issue(CMD_STOP, 8'h00, 1'b0);
        settle();
        cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));

        // shortest half periods
        set_timing('0, LIMIT_W'(1));
        issue(CMD_START, 8'h00, 1'b0);
        issue(CMD_WRITE, 8'hA5, 1'b0);
        issue(CMD_STOP, 8'h00, 1'b0);
        set_timing(HALF_W'(1), LIMIT_W'(3));
        issue(CMD_READ, 8'h00, 1'b1);
        issue(CMD_WRITE, 8'h5A, 1'b1);

        // longer half period, longest stretch limit
        set_timing(HALF_W'(12), '1);
        issue(CMD_START, 8'h00, 1'b0);
        issue(CMD_STOP, 8'h00, 1'b0);

        while (accepted_ticks < TOTAL_TICKS)
        begin
            random_setting();
            phase_start = accepted_ticks;
            while (accepted_ticks - phase_start < PHASE_TICKS)
                random_transaction();
        end

        settle();
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

>>> i2c_master_bit_engine.f
hdl/i2cm_pkg.sv
hdl/i2cm_ifs.sv
hdl/i2cm_front.sv
hdl/i2cm_fifo.sv
hdl/i2cm_back.sv
hdl/i2c_master_bit_engine.sv
bench/testbench.sv
